// File: rtl/framed_packet_receiver_crc8_core_defines.svh
// assertion helpers used by the rtl engine
`ifndef FRAMED_PACKET_RECEIVER_CRC8_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CRC8_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRPR_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frpr check failed: name");

// next-cycle implication, checked outside reset
`define FRPR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frpr check failed: name");

`endif

// File: rtl/frpr_pkg.sv
`timescale 1ns / 1ps

package frpr_pkg;

    // field widths
    localparam int GAP_W      = 16;
    localparam int LIM_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 3;

    // default counter width
    localparam int COUNTER_BITS_DEF = 20;

    // protocol constants
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;

    // frame positions: hunting, type byte, four value bytes, crc byte
    localparam logic [POS_W-1:0] POS_HUNT  = 3'd0;
    localparam logic [POS_W-1:0] POS_TYPE  = 3'd1;
    localparam logic [POS_W-1:0] POS_VAL0  = 3'd2;
    localparam logic [POS_W-1:0] POS_VAL1  = 3'd3;
    localparam logic [POS_W-1:0] POS_VAL2  = 3'd4;
    localparam logic [POS_W-1:0] POS_VAL3  = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC   = 3'd6;

    // register reset values
    localparam logic [GAP_W-1:0] GAP_RST      = 16'd200;
    localparam logic [LIM_W-1:0] SILENCE_RST  = 20'd20000;
    localparam logic [LIM_W-1:0] INTERVAL_RST = 20'd2000;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        EV_GOOD     = 2'd0,
        EV_CRC_FAIL = 2'd1,
        EV_PING     = 2'd2
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP      = 2'd0,
        CFG_SILENCE  = 2'd1,
        CFG_INTERVAL = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [GAP_W-1:0] gap_limit;
        logic [LIM_W-1:0] silence_limit;
        logic [LIM_W-1:0] ping_interval;
    } cfg_regs_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  pkt_type;
        logic [31:0] pkt_value;
    } result_t;

    // one byte of crc-8, msb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/frpr_item_if.sv
`timescale 1ns / 1ps

interface frpr_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// File: rtl/frpr_result_if.sv
`timescale 1ns / 1ps

interface frpr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  pkt_type;
    logic [31:0] pkt_value;

    modport source (output valid, output event_res, output pkt_type, output pkt_value,
                    input ready);
    modport sink   (input valid, input event_res, input pkt_type, input pkt_value,
                    output ready);
endinterface

// File: rtl/frpr_cfg_if.sv
`timescale 1ns / 1ps

interface frpr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [frpr_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [frpr_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/frpr_cfg.sv
`timescale 1ns / 1ps

module frpr_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    frpr_cfg_if.sink             cfg,
    output frpr_pkg::cfg_regs_t  regs
);

    frpr_pkg::cfg_regs_t regs_reg;
    frpr_pkg::cfg_regs_t regs_next;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register decode, unknown index ignored
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (frpr_pkg::cfg_idx_t'(cfg.reg_index))
                frpr_pkg::CFG_GAP:
                    regs_next.gap_limit = cfg.wdata[frpr_pkg::GAP_W-1:0];
                frpr_pkg::CFG_SILENCE:
                    regs_next.silence_limit = cfg.wdata[frpr_pkg::LIM_W-1:0];
                frpr_pkg::CFG_INTERVAL:
                    regs_next.ping_interval = cfg.wdata[frpr_pkg::LIM_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.gap_limit     <= frpr_pkg::GAP_RST;
            regs_reg.silence_limit <= frpr_pkg::SILENCE_RST;
            regs_reg.ping_interval <= frpr_pkg::INTERVAL_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: rtl/frpr_engine.sv
`timescale 1ns / 1ps
`include "framed_packet_receiver_crc8_core_defines.svh"

module frpr_engine #(
    parameter int COUNTER_BITS = frpr_pkg::COUNTER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  frpr_pkg::kind_t      kind,
    input  logic [7:0]           rx_byte,
    input  frpr_pkg::cfg_regs_t  regs,
    output logic                 res_valid,
    output frpr_pkg::result_t    res
);

    localparam int CMP_W = (COUNTER_BITS > frpr_pkg::LIM_W) ? COUNTER_BITS : frpr_pkg::LIM_W;

    logic [frpr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                 crc_reg, crc_next;
    logic [7:0]                 type_reg, type_next;
    logic [31:0]                value_reg, value_next;
    logic [COUNTER_BITS-1:0]    since_byte_reg, since_byte_next;
    logic [COUNTER_BITS-1:0]    since_ping_reg, since_ping_next;
    logic [COUNTER_BITS-1:0]    since_byte_inc, since_ping_inc;
    logic                       byte_step;
    logic                       start_step;
    logic                       crc_step;
    logic                       ping_out;
    logic                       frame_out;

    // saturating tick counts
    assign since_byte_inc = (since_byte_reg == '1) ? since_byte_reg
                                                   : since_byte_reg + 1'b1;
    assign since_ping_inc = (since_ping_reg == '1) ? since_ping_reg
                                                   : since_ping_reg + 1'b1;

    // one word per call: byte framing or tick timing
    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        type_next       = type_reg;
        value_next      = value_reg;
        since_byte_next = since_byte_reg;
        since_ping_next = since_ping_reg;
        res_valid       = 1'b0;
        res.ev          = frpr_pkg::EV_GOOD;
        res.pkt_type    = 8'h00;
        res.pkt_value   = 32'h0;
        if (step)
        begin
            if (kind == frpr_pkg::KIND_BYTE)
            begin
                since_byte_next = '0;
                if (rx_byte == frpr_pkg::START_BYTE)
                begin
                    // start byte always restarts the frame
                    pos_next = frpr_pkg::POS_TYPE;
                    crc_next = frpr_pkg::CRC_INIT;
                end
                else if (pos_reg == frpr_pkg::POS_CRC)
                begin
                    pos_next  = frpr_pkg::POS_HUNT;
                    res_valid = 1'b1;
                    if (rx_byte == crc_reg)
                    begin
                        res.ev        = frpr_pkg::EV_GOOD;
                        res.pkt_type  = type_reg;
                        res.pkt_value = value_reg;
                    end
                    else
                    begin
                        res.ev = frpr_pkg::EV_CRC_FAIL;
                    end
                end
                else if (pos_reg != frpr_pkg::POS_HUNT)
                begin
                    crc_next = frpr_pkg::crc8_byte(crc_reg, rx_byte);
                    pos_next = pos_reg + 1'b1;
                    case (pos_reg)
                        frpr_pkg::POS_TYPE: type_next         = rx_byte;
                        frpr_pkg::POS_VAL0: value_next[7:0]   = rx_byte;
                        frpr_pkg::POS_VAL1: value_next[15:8]  = rx_byte;
                        frpr_pkg::POS_VAL2: value_next[23:16] = rx_byte;
                        frpr_pkg::POS_VAL3: value_next[31:24] = rx_byte;
                        default:            type_next         = type_reg;
                    endcase
                end
            end
            else
            begin
                since_byte_next = since_byte_inc;
                since_ping_next = since_ping_inc;
                // gap drop
                if (pos_reg != frpr_pkg::POS_HUNT &&
                    CMP_W'(since_byte_inc) > CMP_W'(regs.gap_limit))
                begin
                    pos_next = frpr_pkg::POS_HUNT;
                end
                // ping when silent and the last ping is old enough
                if (CMP_W'(since_byte_inc) > CMP_W'(regs.silence_limit) &&
                    CMP_W'(since_ping_inc) > CMP_W'(regs.ping_interval))
                begin
                    since_ping_next = '0;
                    res_valid       = 1'b1;
                    res.ev          = frpr_pkg::EV_PING;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= frpr_pkg::POS_HUNT;
            since_byte_reg <= '0;
            since_ping_reg <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            since_byte_reg <= since_byte_next;
            since_ping_reg <= since_ping_next;
        end
    end

    // frame payload and running crc
    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        type_reg  <= type_next;
        value_reg <= value_next;
    end

    // terms for the checks below
    assign byte_step  = step && kind == frpr_pkg::KIND_BYTE;
    assign start_step = byte_step && rx_byte == frpr_pkg::START_BYTE;
    assign crc_step   = byte_step && pos_reg == frpr_pkg::POS_CRC;
    assign ping_out   = res_valid && res.ev == frpr_pkg::EV_PING;
    assign frame_out  = res_valid && res.ev != frpr_pkg::EV_PING;

    `FRPR_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, pos_reg <= frpr_pkg::POS_CRC)
    `FRPR_ASSERT_SAME(a_ping_on_tick, clk, rst_n, ping_out, kind == frpr_pkg::KIND_TICK)
    `FRPR_ASSERT_SAME(a_frame_end, clk, rst_n, frame_out, crc_step)
    `FRPR_ASSERT_NEXT(a_start_restart, clk, rst_n, start_step, pos_reg == frpr_pkg::POS_TYPE)

endmodule

// File: rtl/frpr_out_reg.sv
`timescale 1ns / 1ps

module frpr_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  frpr_pkg::result_t  res,
    output logic               free,
    frpr_result_if.source      result
);

    logic              valid_reg, valid_next;
    frpr_pkg::result_t data_reg;

    // slot can take a word when empty or being drained
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid     = valid_reg;
    assign result.event_res = data_reg.ev;
    assign result.pkt_type  = data_reg.pkt_type;
    assign result.pkt_value = data_reg.pkt_value;

endmodule

// File: rtl/framed_packet_receiver_crc8_core.sv
`timescale 1ns / 1ps
// channel  | role   | handshake     | payload
// item     | sink   | valid/ready   | kind, rx_byte
// result   | source | valid/ready   | event_res, pkt_type, pkt_value
// cfg      | sink   | valid/ready   | reg_index, wdata (ready always high)
//
// one word per cycle sustained while the result slot is free: input register,
// framing, crc and timer logic in the engine, then the result register. a word
// waits in the input register, then its result is loaded into the result slot.
// the crc is kept as a running byte-wise value that folds in each framed byte.
// reset clears frame position, both ms counters, valid flags and the registers
// to their defaults. a stalled result holds; the input register still moves
// whenever the result slot is empty or draining.

module framed_packet_receiver_crc8_core #(
    parameter int COUNTER_BITS = frpr_pkg::COUNTER_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    frpr_item_if.sink      item,
    frpr_result_if.source  result,
    frpr_cfg_if.sink       cfg
);

    logic                in_valid_reg, in_valid_next;
    frpr_pkg::kind_t     kind_reg;
    logic [7:0]          byte_reg;
    logic                out_free;
    logic                step;
    logic                res_valid;
    frpr_pkg::result_t   res;
    frpr_pkg::cfg_regs_t regs;

    // input register advances when the engine can hand off its result
    assign step       = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            kind_reg <= frpr_pkg::kind_t'(item.kind);
            byte_reg <= item.rx_byte;
        end
    end

    frpr_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    frpr_engine #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .kind      (kind_reg),
        .rx_byte   (byte_reg),
        .regs      (regs),
        .res_valid (res_valid),
        .res       (res)
    );

    frpr_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_valid),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

endmodule

// File: tb/framed_packet_receiver_crc8_core_tb.sv
`timescale 1ns / 1ps

module framed_packet_receiver_crc8_core_tb;

    localparam int CNT_W           = frpr_pkg::COUNTER_BITS_DEF;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 216;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 8;
    localparam int QUIET_LIMIT     = 4000;
    localparam int MAX_REPORTS     = 10;

    // index past the last register, must be ignored
    localparam logic [frpr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // register settings used by the phases
    localparam int SET_RESET = 0;
    localparam int SET_LOW   = 1;
    localparam int SET_HIGH  = 2;
    localparam int SET_MID   = 3;

    typedef struct packed {
        frpr_pkg::kind_t kind;
        logic [7:0]      data;
    } line_word_t;

    logic clk = 1'b0;
    logic rst_n;

    frpr_item_if   item_ch();
    frpr_result_if result_ch();
    frpr_cfg_if    cfg_ch();

    framed_packet_receiver_crc8_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // words waiting to be sent and events waiting to come out
    line_word_t          pending_words[$];
    frpr_pkg::result_t   expected_events[$];

    // frame tracker state
    logic [frpr_pkg::POS_W-1:0] trk_pos;
    logic [7:0]                 trk_buf [6];
    logic [CNT_W-1:0]           ms_byte;
    logic [CNT_W-1:0]           ms_ping;
    frpr_pkg::cfg_regs_t        trk_cfg;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served;
    int hold_left;

    int words_queued  = 0;
    int words_in      = 0;
    int ticks_in      = 0;
    int good_seen     = 0;
    int crc_fail_seen = 0;
    int ping_seen     = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    // crc-8 over the five frame body bytes, byte k at bits 8k+7..8k
    function automatic logic [7:0] frame_crc(input logic [39:0] body);
        logic [7:0] c;
        c = frpr_pkg::CRC_INIT;
        for (int k = 0; k < 5; k++)
        begin
            c = c ^ body[8*k +: 8];
            for (int b = 0; b < 8; b++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ frpr_pkg::CRC_POLY) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // advance the frame tracker by one accepted word
    function automatic void track_word(input line_word_t w);
        frpr_pkg::result_t r;
        logic [39:0]       body;
        bit                emit;
        emit = 1'b0;
        if (w.kind == frpr_pkg::KIND_BYTE)
        begin
            ms_byte = '0;
            if (w.data == frpr_pkg::START_BYTE)
            begin
                trk_pos = frpr_pkg::POS_TYPE;
            end
            else if (trk_pos != frpr_pkg::POS_HUNT)
            begin
                trk_buf[trk_pos - 1] = w.data;
                if (trk_pos == frpr_pkg::POS_CRC)
                begin
                    trk_pos = frpr_pkg::POS_HUNT;
                    body = {trk_buf[4], trk_buf[3], trk_buf[2], trk_buf[1], trk_buf[0]};
                    emit = 1'b1;
                    if (trk_buf[5] == frame_crc(body))
                    begin
                        r = '{frpr_pkg::EV_GOOD, trk_buf[0],
                              {trk_buf[4], trk_buf[3], trk_buf[2], trk_buf[1]}};
                    end
                    else
                    begin
                        r = '{frpr_pkg::EV_CRC_FAIL, 8'h00, 32'h0};
                    end
                end
                else
                begin
                    trk_pos = trk_pos + 1'b1;
                end
            end
        end
        else
        begin
            // both counters saturate, then gap drop, then ping check
            ms_byte = (ms_byte == '1) ? ms_byte : ms_byte + 1'b1;
            ms_ping = (ms_ping == '1) ? ms_ping : ms_ping + 1'b1;
            if (trk_pos != frpr_pkg::POS_HUNT && ms_byte > trk_cfg.gap_limit)
            begin
                trk_pos = frpr_pkg::POS_HUNT;
            end
            if (ms_byte > trk_cfg.silence_limit && ms_ping > trk_cfg.ping_interval)
            begin
                ms_ping = '0;
                r = '{frpr_pkg::EV_PING, 8'h00, 32'h0};
                emit = 1'b1;
            end
        end
        if (emit)
        begin
            expected_events.push_back(r);
        end
    endfunction

    task automatic push_word(input frpr_pkg::kind_t k, input logic [7:0] d);
        line_word_t w;
        w.kind = k;
        w.data = d;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(frpr_pkg::KIND_TICK, 8'($urandom));
    endtask

    // start byte, type, value little-endian, check byte; ticks may fall inside
    task automatic push_frame(input logic [7:0] ftype, input logic [31:0] fval,
                              input bit bad_crc, input int tick_pct);
        logic [39:0] body;
        logic [7:0]  chk;
        body = {fval, ftype};
        chk = frame_crc(body);
        if (bad_crc)
        begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        push_word(frpr_pkg::KIND_BYTE, frpr_pkg::START_BYTE);
        for (int k = 0; k < 5; k++)
        begin
            if ($urandom_range(99) < tick_pct)
            begin
                push_word(frpr_pkg::KIND_TICK, 8'($urandom));
            end
            push_word(frpr_pkg::KIND_BYTE, body[8*k +: 8]);
        end
        push_word(frpr_pkg::KIND_BYTE, chk);
    endtask

    // mostly frames, some bad-crc, plus tick bursts, stray bytes, cut-off frames
    task automatic push_random_chunk();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            push_frame(8'($urandom), $urandom, $urandom_range(99) < 15, 8);
        end
        else if (r < 76)
        begin
            push_ticks(($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8));
        end
        else if (r < 88)
        begin
            push_word(frpr_pkg::KIND_BYTE, 8'($urandom));
        end
        else
        begin
            push_word(frpr_pkg::KIND_BYTE, frpr_pkg::START_BYTE);
            repeat ($urandom_range(1, 5)) push_word(frpr_pkg::KIND_BYTE, 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [frpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frpr_pkg::CFG_DATA_W-1:0] wd);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= wd;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            frpr_pkg::CFG_GAP:      trk_cfg.gap_limit     = wd[frpr_pkg::GAP_W-1:0];
            frpr_pkg::CFG_SILENCE:  trk_cfg.silence_limit = wd[frpr_pkg::LIM_W-1:0];
            frpr_pkg::CFG_INTERVAL: trk_cfg.ping_interval = wd[frpr_pkg::LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input int which);
        case (which)
            SET_LOW:
            begin
                write_reg(frpr_pkg::CFG_GAP, '0);
                write_reg(frpr_pkg::CFG_SILENCE, '0);
                write_reg(frpr_pkg::CFG_INTERVAL, '0);
            end
            SET_HIGH:
            begin
                // upper bits of the gap write are dropped
                write_reg(frpr_pkg::CFG_GAP, '1);
                write_reg(frpr_pkg::CFG_SILENCE, '1);
                write_reg(frpr_pkg::CFG_INTERVAL, '1);
            end
            SET_MID:
            begin
                write_reg(frpr_pkg::CFG_GAP, frpr_pkg::CFG_DATA_W'($urandom_range(0, 6)));
                write_reg(frpr_pkg::CFG_SILENCE, frpr_pkg::CFG_DATA_W'($urandom_range(0, 40)));
                write_reg(frpr_pkg::CFG_INTERVAL, frpr_pkg::CFG_DATA_W'($urandom_range(0, 30)));
            end
            default: ;
        endcase
    endtask

    // wait until nothing is queued or owed, then let the pipeline empty
    task automatic drain_and_settle();
        do @(posedge clk);
        while (pending_words.size() != 0 || item_ch.valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int phase_setting(input int p);
        case (p)
            0:       return SET_RESET;
            1, 5:    return SET_LOW;
            2, 7:    return SET_HIGH;
            default: return SET_MID;
        endcase
    endfunction

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // word driver
    always @(posedge clk or negedge rst_n)
    begin
        line_word_t w;
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.kind    <= 1'b0;
            item_ch.rx_byte <= 8'h00;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                w = pending_words.pop_front();
                item_ch.valid   <= 1'b1;
                item_ch.kind    <= w.kind;
                item_ch.rx_byte <= w.data;
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // result ready, with random stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_served     <= 0;
            hold_left       <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served     <= hold_requests;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor: check results, then track accepted words
    always @(posedge clk)
    begin
        frpr_pkg::result_t exp_ev;
        line_word_t        w;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                case (result_ch.event_res)
                    frpr_pkg::EV_GOOD:     good_seen++;
                    frpr_pkg::EV_CRC_FAIL: crc_fail_seen++;
                    frpr_pkg::EV_PING:     ping_seen++;
                    default: ;
                endcase
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("unexpected event: ev %0d type %02h value %08h",
                                 result_ch.event_res, result_ch.pkt_type,
                                 result_ch.pkt_value);
                    end
                end
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (result_ch.event_res !== exp_ev.ev
                        || result_ch.pkt_type !== exp_ev.pkt_type
                        || result_ch.pkt_value !== exp_ev.pkt_value)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display({"mismatch: expected ev %0d type %02h value %08h,",
                                      " got ev %0d type %02h value %08h"},
                                     exp_ev.ev, exp_ev.pkt_type, exp_ev.pkt_value,
                                     result_ch.event_res, result_ch.pkt_type,
                                     result_ch.pkt_value);
                        end
                    end
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                w.kind = frpr_pkg::kind_t'(item_ch.kind);
                w.data = item_ch.rx_byte;
                words_in++;
                if (w.kind == frpr_pkg::KIND_TICK)
                begin
                    ticks_in++;
                end
                track_word(w);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // reset, register settings and word stream
    initial
    begin
        item_ch.valid    = 1'b0;
        item_ch.kind     = 1'b0;
        item_ch.rx_byte  = 8'h00;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata     = '0;
        rst_n            = 1'b0;

        trk_pos = frpr_pkg::POS_HUNT;
        ms_byte = '0;
        ms_ping = '0;
        trk_cfg.gap_limit     = frpr_pkg::GAP_RST;
        trk_cfg.silence_limit = frpr_pkg::SILENCE_RST;
        trk_cfg.ping_interval = frpr_pkg::INTERVAL_RST;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                drain_and_settle();
            end
            load_setting(phase_setting(p));
            if (p == 3)
            begin
                write_reg(CFG_SPARE, frpr_pkg::CFG_DATA_W'($urandom));
            end
            @(negedge clk);

            // idle mix: none, sender only, receiver only, both
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 46;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 46;
                end
                default:
                begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 28;
                end
            endcase

            // long receiver hold-off so the block backs up into its input
            if (p == 4)
            begin
                hold_requests++;
                push_frame(8'($urandom), $urandom, 1'b0, 0);
            end

            if (p == 0)
            begin
                // stray byte while hunting
                push_word(frpr_pkg::KIND_BYTE, 8'h55);
                // all-ones frame
                push_frame(8'hFF, 32'hFFFF_FFFF, 1'b0, 0);
                // start byte in the check slot restarts the frame
                push_word(frpr_pkg::KIND_BYTE, frpr_pkg::START_BYTE);
                repeat (5) push_word(frpr_pkg::KIND_BYTE, 8'h00);
                push_word(frpr_pkg::KIND_BYTE, frpr_pkg::START_BYTE);
                // restarted frame ends on a wrong check byte
                repeat (5) push_word(frpr_pkg::KIND_BYTE, 8'h00);
                push_word(frpr_pkg::KIND_BYTE, frame_crc(40'h0) ^ 8'h01);
                push_ticks(2);
            end

            while (words_queued < (p + 1) * WORDS_PER_PHASE)
            begin
                push_random_chunk();
            end
        end

        drain_and_settle();

        $display("covered %0d words (%0d ticks) across %0d register settings and idle mixes",
                 words_in, ticks_in, PHASES);
        $display("checked %0d good frames, %0d crc failures, %0d pings; %0d mismatches",
                 good_seen, crc_fail_seen, ping_seen, fail_count);
        if (expected_events.size() != 0)
        begin
            $display("%0d expected events never arrived", expected_events.size());
        end
        if (fail_count == 0 && expected_events.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
